@@ sv/pft_pkg.sv @@
package pft_pkg;

    localparam int unsigned PROC_ID_W = 2;
    localparam int unsigned VADDR_W   = 32;
    localparam int unsigned PADDR_W   = 18;
    localparam int unsigned FRAME_W   = 6;

    typedef struct packed {
        logic [PROC_ID_W-1:0] proc_id;
        logic [VADDR_W-1:0]   virt_addr;
    } pft_in_t;

    typedef struct packed {
        logic [PADDR_W-1:0] phys_addr;
        logic [FRAME_W-1:0] frame_used;
        logic               was_hit;
        logic               evicted_valid;
    } pft_out_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic lookup;
        logic update;
        logic rd_pn;
        logic unlink;
        logic link_f;
        logic link_h;
    } pft_cmd_t;

    typedef struct packed {
        logic hit;
        logic lru;
        logic is_head;
        logic clr_last;
    } pft_sts_t;

    typedef enum logic [7:0] {
        ST_INIT   = 8'b00000001,
        ST_IDLE   = 8'b00000010,
        ST_LOOKUP = 8'b00000100,
        ST_DECIDE = 8'b00001000,
        ST_UNLINK = 8'b00010000,
        ST_LINKF  = 8'b00100000,
        ST_LINKH  = 8'b01000000,
        ST_OUT    = 8'b10000000
    } pft_state_t;

endpackage

@@ sv/pft_ctrl.sv @@
module pft_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  pft_pkg::pft_sts_t   sts,
    output pft_pkg::pft_cmd_t   cmd
);

    pft_pkg::pft_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pft_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall  = (state_reg != pft_pkg::ST_IDLE);
    assign out_valid = (state_reg == pft_pkg::ST_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            pft_pkg::ST_INIT:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = pft_pkg::ST_IDLE;
                end
            end
            pft_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = pft_pkg::ST_LOOKUP;
                end
            end
            pft_pkg::ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = pft_pkg::ST_DECIDE;
            end
            pft_pkg::ST_DECIDE:
            begin
                cmd.update = 1'b1;
                if (sts.hit && sts.lru && !sts.is_head)
                begin
                    cmd.rd_pn = 1'b1;
                    state_next = pft_pkg::ST_UNLINK;
                end
                else
                begin
                    state_next = pft_pkg::ST_OUT;
                end
            end
            pft_pkg::ST_UNLINK:
            begin
                cmd.unlink = 1'b1;
                state_next = pft_pkg::ST_LINKF;
            end
            pft_pkg::ST_LINKF:
            begin
                cmd.link_f = 1'b1;
                state_next = pft_pkg::ST_LINKH;
            end
            pft_pkg::ST_LINKH:
            begin
                cmd.link_h = 1'b1;
                state_next = pft_pkg::ST_OUT;
            end
            pft_pkg::ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = pft_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pft_pkg::ST_IDLE;
            end
        endcase
    end

    a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("out_valid while idle");
    a_decide_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pft_pkg::ST_DECIDE |-> $past(state_reg) == pft_pkg::ST_LOOKUP)
        else $error("decide without lookup");
    a_linkh_after_linkf: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pft_pkg::ST_LINKH |-> $past(state_reg) == pft_pkg::ST_LINKF)
        else $error("link out of order");
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid) else $error("stalled beat dropped");

endmodule

@@ sv/pft_dpath.sv @@
module pft_dpath
#(
    parameter int unsigned FRAME_COUNT = 64,
    parameter int unsigned PROC_COUNT  = 4,
    parameter int unsigned OFFSET_BITS = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                policy_we,
    input  logic                policy_wdata,
    input  pft_pkg::pft_in_t    in_data,
    input  pft_pkg::pft_cmd_t   cmd,
    output pft_pkg::pft_sts_t   sts,
    output pft_pkg::pft_out_t   out_data
);

    localparam int unsigned FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int unsigned VPW = pft_pkg::VADDR_W - OFFSET_BITS;
    localparam int unsigned PW = pft_pkg::PROC_ID_W;
    localparam int unsigned PAW = FW + OFFSET_BITS;

    logic                   policy_reg;
    logic [FRAME_COUNT-1:0] in_use_reg;
    logic [PW-1:0]          owner_reg [FRAME_COUNT];
    logic [VPW-1:0]         vpage_reg [FRAME_COUNT];
    logic [FW-1:0]          next_mem  [FRAME_COUNT];
    logic [FW-1:0]          prev_mem  [FRAME_COUNT];
    logic [FW-1:0]          oldest_reg;
    logic [FW-1:0]          clr_reg;

    logic [PW-1:0]          pid_reg;
    logic [VPW-1:0]         vp_reg;
    logic [OFFSET_BITS-1:0] off_reg;
    logic                   hit_reg;
    logic                   evict_reg;
    logic [FW-1:0]          frame_reg;
    logic [FW-1:0]          hp_reg;
    logic [FW-1:0]          nrd_reg, prd_reg;

    logic [FRAME_COUNT-1:0] match;
    logic [FW-1:0]          mfr;
    logic                   mhit;
    logic [PW-1:0]          pid_in;

    logic [FW-1:0]          nwa, nwd, pwa, pwd, nra, pra;
    logic                   nwe, pwe;

    function automatic logic [FW-1:0] fadd(input logic [FW-1:0] a, input logic up);
        logic [FW:0] s;
        begin
            if (up)
            begin
                s = {1'b0, a} + 1'b1;
                if (s == (FW+1)'(FRAME_COUNT)) s = '0;
            end
            else
            begin
                s = (a == '0) ? (FW+1)'(FRAME_COUNT - 1) : ({1'b0, a} - 1'b1);
            end
            fadd = s[FW-1:0];
        end
    endfunction

    // proc_id is narrow, so one compare and subtract reduces it
    always_comb
    begin
        pid_in = in_data.proc_id;
        if (PROC_COUNT == 1)
        begin
            pid_in = '0;
        end
        else if (PROC_COUNT < (1 << PW) && in_data.proc_id >= PW'(PROC_COUNT))
        begin
            pid_in = in_data.proc_id - PW'(PROC_COUNT);
        end
    end

    always_comb
    begin
        for (int i = 0; i < FRAME_COUNT; i++)
        begin
            match[i] = in_use_reg[i] && owner_reg[i] == pid_reg && vpage_reg[i] == vp_reg;
        end
    end

    always_comb
    begin
        mfr = '0;
        mhit = 1'b0;
        for (int i = FRAME_COUNT - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                mfr = FW'(i);
                mhit = 1'b1;
            end
        end
    end

    assign sts.hit      = hit_reg;
    assign sts.lru      = policy_reg;
    assign sts.is_head  = (frame_reg == oldest_reg);
    assign sts.clr_last = (clr_reg == FW'(FRAME_COUNT - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= 1'b1;
            in_use_reg <= '0;
            oldest_reg <= '0;
            clr_reg    <= '0;
        end
        else
        begin
            if (policy_we)
            begin
                policy_reg <= policy_wdata;
            end
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.update)
            begin
                if (!hit_reg)
                begin
                    in_use_reg[frame_reg] <= 1'b1;
                    oldest_reg <= nrd_reg;
                end
                else if (policy_reg && frame_reg == oldest_reg)
                begin
                    oldest_reg <= nrd_reg;
                end
            end
        end
    end

    // next/prev memories: one write port each, registered read
    // reads default to the oldest frame, so its links land in DECIDE
    always_comb
    begin
        nra = oldest_reg;
        pra = oldest_reg;
        if (cmd.rd_pn)
        begin
            nra = frame_reg;
            pra = frame_reg;
        end
        nwe = 1'b0;
        pwe = 1'b0;
        nwa = clr_reg;
        nwd = fadd(clr_reg, 1'b1);
        pwa = clr_reg;
        pwd = fadd(clr_reg, 1'b0);
        if (cmd.clear)
        begin
            nwe = 1'b1;
            pwe = 1'b1;
        end
        if (cmd.unlink)
        begin
            nwe = 1'b1;
            nwa = prd_reg;
            nwd = nrd_reg;
            pwe = 1'b1;
            pwa = nrd_reg;
            pwd = prd_reg;
        end
        if (cmd.link_f)
        begin
            nwe = 1'b1;
            nwa = frame_reg;
            nwd = oldest_reg;
            pwe = 1'b1;
            pwa = frame_reg;
            pwd = hp_reg;
        end
        if (cmd.link_h)
        begin
            nwe = 1'b1;
            nwa = hp_reg;
            nwd = frame_reg;
            pwe = 1'b1;
            pwa = oldest_reg;
            pwd = frame_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        nrd_reg <= next_mem[nra];
        prd_reg <= prev_mem[pra];
        if (nwe) next_mem[nwa] <= nwd;
        if (pwe) prev_mem[pwa] <= pwd;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pid_reg <= pid_in;
            vp_reg  <= in_data.virt_addr[pft_pkg::VADDR_W-1:OFFSET_BITS];
            off_reg <= in_data.virt_addr[OFFSET_BITS-1:0];
        end
        if (cmd.lookup)
        begin
            hit_reg   <= mhit;
            frame_reg <= mhit ? mfr : oldest_reg;
            evict_reg <= !mhit && in_use_reg[oldest_reg];
        end
        if (cmd.update && !hit_reg)
        begin
            owner_reg[frame_reg] <= pid_reg;
            vpage_reg[frame_reg] <= vp_reg;
        end
        // prev of the oldest frame, taken again if the unlink rewrites it
        if (cmd.rd_pn)
        begin
            hp_reg <= prd_reg;
        end
        else if (cmd.unlink && nrd_reg == oldest_reg)
        begin
            hp_reg <= prd_reg;
        end
    end

    logic [PAW-1:0] pa_full;
    assign pa_full = {frame_reg, off_reg};
    assign out_data.phys_addr     = pft_pkg::PADDR_W'(pa_full);
    assign out_data.frame_used    = pft_pkg::FRAME_W'(frame_reg);
    assign out_data.was_hit       = hit_reg;
    assign out_data.evicted_valid = evict_reg;

endmodule

@@ sv/page_frame_translate_fifo_lru_unit.sv @@
// Page frame translator with FIFO or LRU replacement.
// Input channel in_valid/in_stall carries proc_id and virt_addr per beat.
// Output channel out_valid/out_stall returns phys_addr, frame_used,
// was_hit and evicted_valid, one result beat per input beat.
// policy_we/policy_wdata writes replacement_policy (0 FIFO, 1 LRU); write it
// only while no beat is in flight.
// One item in flight: a lookup compares all frames in parallel, and the
// linked-list order memories (one write port each) hold the replacement order.
// Steps: the accepting edge enters LOOKUP, then DECIDE; faults and hits that
// leave the order alone or hit the oldest frame go on to OUT, while an LRU
// hit that moves a frame off the middle of the order passes UNLINK, LINKF
// and LINKH first. The next beat is accepted the cycle after the result beat.
// Reset empties all frames, sets LRU policy and the oldest pointer to 0; a
// clearing pass over every frame then builds the identity ring, with
// in_stall high throughout.
// While out_stall is high the result holds and in_stall stays high.
module page_frame_translate_fifo_lru_unit
#(
    parameter int unsigned FRAME_COUNT = 64,
    parameter int unsigned PROC_COUNT  = 4,
    parameter int unsigned OFFSET_BITS = 12
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              policy_we,
    input  logic              policy_wdata,
    input  logic              in_valid,
    output logic              in_stall,
    input  pft_pkg::pft_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output pft_pkg::pft_out_t out_data
);

    pft_pkg::pft_cmd_t cmd;
    pft_pkg::pft_sts_t sts;

    pft_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    pft_dpath #(
        .FRAME_COUNT (FRAME_COUNT),
        .PROC_COUNT  (PROC_COUNT),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .policy_we    (policy_we),
        .policy_wdata (policy_wdata),
        .in_data      (in_data),
        .cmd          (cmd),
        .sts          (sts),
        .out_data     (out_data)
    );

endmodule
